// ===== src/tse_pkg.sv =====
// tse_pkg: shared types and constants of the table search engine
// no dependencies; used by tse_search_ctrl, table_search_engine and tse_checker
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

  // default geometry of the table
  localparam int DEF_TABLE_DEPTH = 128;
  localparam int DEF_VALUE_WIDTH = 32;

  // fixed field widths of the stream beats
  localparam int OPCODE_W    = 2;
  localparam int INDEX_W     = 7;
  localparam int FIELD_W     = 32;
  localparam int LEN_W       = 8;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 8;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_TABLE_LENGTH = 1'b0;  // word index of table_length

  // item operations
  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_LINEAR  = 2'd1,
    OP_ORDERED = 2'd2,
    OP_BINARY  = 2'd3
  } op_t;

  // one search result
  typedef struct packed {
    logic [INDEX_W-1:0] match_index;
    logic               found;
  } res_t;

endpackage

`default_nettype wire

// ===== src/tse_table_mem.sv =====
// tse_table_mem: single-port-write, single-port-read table memory
// registered read data; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module tse_table_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tse_search_ctrl.sv =====
// tse_search_ctrl: search sequencer and result register
// drives the table memory read port; uses tse_pkg types
`timescale 1ns / 1ps
`default_nettype none

module tse_search_ctrl #(
  parameter int TABLE_DEPTH = tse_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = tse_pkg::DEF_VALUE_WIDTH,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // search request from the input side
  input  wire logic                          start,
  input  wire tse_pkg::op_t                  start_op,
  input  wire logic signed [VALUE_WIDTH-1:0] start_key,
  input  wire logic [CNT_W-1:0]              start_len,
  output logic                               idle,
  // table read port
  output logic                               mem_re,
  output logic [IDX_W-1:0]                   mem_raddr,
  input  wire logic [VALUE_WIDTH-1:0]        mem_rdata,
  // result side
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output tse_pkg::res_t                      res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BIN_PROBE,
    ST_BIN_CMP,
    ST_DONE
  } state_t;

  state_t                  state_r,     state_nxt;
  logic                    ordered_r,   ordered_nxt;
  logic signed [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]        len_r,       len_nxt;
  logic [CNT_W-1:0]        issue_r,     issue_nxt;
  logic [IDX_W-1:0]        cmp_idx_r,   cmp_idx_nxt;
  logic                    cmp_vld_r,   cmp_vld_nxt;
  logic [CNT_W-1:0]        lo_r,        lo_nxt;
  logic [CNT_W-1:0]        hi1_r,       hi1_nxt;   // upper bound plus one
  logic [IDX_W-1:0]        mid_r,       mid_nxt;
  logic                    hit_r,       hit_nxt;
  logic [IDX_W-1:0]        hit_idx_r,   hit_idx_nxt;
  logic                    out_vld_r,   out_vld_nxt;
  tse_pkg::res_t           out_res_r,   out_res_nxt;

  logic signed [VALUE_WIDTH-1:0] entry;
  logic                    key_eq;
  logic                    key_lt;
  logic [CNT_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid_probe;
  logic                    scan_rd;

  assign entry     = $signed(mem_rdata);
  assign key_eq    = (key_r == entry);
  assign key_lt    = (key_r < entry);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi1_r} - (CNT_W + 1)'(1);
  assign mid_probe = mid_sum[IDX_W:1];
  assign scan_rd   = (issue_r < len_r);

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = out_vld_r;
  assign res       = out_res_r;

  // read port select
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = mid_probe;
    if (state_r == ST_SCAN) begin
      mem_re    = scan_rd;
      mem_raddr = issue_r[IDX_W-1:0];
    end else if (state_r == ST_BIN_PROBE) begin
      mem_re    = (lo_r < hi1_r);
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    ordered_nxt = ordered_r;
    key_nxt     = key_r;
    len_nxt     = len_r;
    issue_nxt   = issue_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    lo_nxt      = lo_r;
    hi1_nxt     = hi1_r;
    mid_nxt     = mid_r;
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    out_vld_nxt = out_vld_r && !res_ready;
    out_res_nxt = out_res_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt     = start_key;
          len_nxt     = start_len;
          ordered_nxt = (start_op == tse_pkg::OP_ORDERED);
          issue_nxt   = '0;
          cmp_vld_nxt = 1'b0;
          lo_nxt      = '0;
          hi1_nxt     = start_len;
          hit_nxt     = 1'b0;
          hit_idx_nxt = '0;
          if (start_len == '0) begin
            state_nxt = ST_DONE;
          end else if (start_op == tse_pkg::OP_BINARY) begin
            state_nxt = ST_BIN_PROBE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      // one read issued and one entry compared per cycle
      ST_SCAN: begin
        cmp_vld_nxt = scan_rd;
        cmp_idx_nxt = issue_r[IDX_W-1:0];
        if (scan_rd) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (cmp_vld_r) begin
          if (key_eq) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            state_nxt   = ST_DONE;
          end else if (ordered_r && key_lt) begin
            state_nxt = ST_DONE;
          end else if (CNT_W'(cmp_idx_r) + CNT_W'(1) == len_r) begin
            state_nxt = ST_DONE;
          end
        end
      end

      // probe the middle of the open range
      ST_BIN_PROBE: begin
        if (lo_r < hi1_r) begin
          mid_nxt   = mid_probe;
          state_nxt = ST_BIN_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // narrow the range with the probed entry
      ST_BIN_CMP: begin
        if (key_eq) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = mid_r;
          state_nxt   = ST_DONE;
        end else begin
          if (key_lt) begin
            hi1_nxt = CNT_W'(mid_r);
          end else begin
            lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
          end
          state_nxt = ST_BIN_PROBE;
        end
      end

      // hand the result to the output register
      ST_DONE: begin
        if (!out_vld_r || res_ready) begin
          out_vld_nxt             = 1'b1;
          out_res_nxt.found       = hit_r;
          out_res_nxt.match_index = tse_pkg::INDEX_W'(hit_idx_r);
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    ordered_r <= ordered_nxt;
    key_r     <= key_nxt;
    len_r     <= len_nxt;
    issue_r   <= issue_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    lo_r      <= lo_nxt;
    hi1_r     <= hi1_nxt;
    mid_r     <= mid_nxt;
    hit_r     <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

`default_nettype wire

// ===== src/table_search_engine.sv =====
// table_search_engine: top level with stream ports and configuration register
// uses tse_pkg, tse_table_mem and tse_search_ctrl
`timescale 1ns / 1ps
`default_nettype none

// A write beat stores one signed entry and gives no result. A search beat
// runs alone through the single read port of the table memory: linear and
// ordered scans read one entry per cycle and may stop early, and binary
// search reads one entry per probe and compares it in a separate step.
// The result waits in an output register; the next beat is taken as soon
// as the search has handed its result over. A table_length above the
// table depth covers the whole table. Entries must be written before a
// search reads them; the memory has no reset.
module table_search_engine #(
  parameter int TABLE_DEPTH = tse_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = tse_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // opcode[1:0], entry_index[8:2], entry_value[40:9], search_key[72:41], zero pad
  input  wire logic [tse_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // found[0], match_index[7:1]
  output logic [tse_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // configuration port
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [tse_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [tse_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [tse_pkg::APB_DATA_W-1:0]          cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > tse_pkg::LEN_W) ? CNT_W : tse_pkg::LEN_W;

  tse_pkg::op_t                      in_opcode;
  logic [tse_pkg::INDEX_W-1:0]       in_entry_index;
  logic signed [tse_pkg::FIELD_W-1:0] in_entry_value;
  logic signed [tse_pkg::FIELD_W-1:0] in_search_key;

  logic [tse_pkg::LEN_W-1:0]         table_length_r;
  logic [CMP_W-1:0]                  len_wide;
  logic [CNT_W-1:0]                  len_cov;

  logic                              in_beat;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_addr;
  logic signed [VALUE_WIDTH-1:0]     wr_value;
  logic signed [VALUE_WIDTH-1:0]     key_ext;

  logic                              idle;
  logic                              mem_re;
  logic [IDX_W-1:0]                  mem_raddr;
  logic [VALUE_WIDTH-1:0]            mem_rdata;
  tse_pkg::res_t                     res;

  // unpack the input beat
  assign in_opcode      = tse_pkg::op_t'(in_tdata[1:0]);
  assign in_entry_index = in_tdata[8:2];
  assign in_entry_value = $signed(in_tdata[40:9]);
  assign in_search_key  = $signed(in_tdata[72:41]);

  assign in_tready = idle;
  assign in_beat   = in_tvalid && in_tready;

  // values and keys wrap to the table word width
  assign wr_value = VALUE_WIDTH'(in_entry_value);
  assign key_ext  = VALUE_WIDTH'(in_search_key);

  // table write, out-of-range positions dropped
  assign wr_en   = in_beat && (in_opcode == tse_pkg::OP_WRITE)
                   && (32'(in_entry_index) < TABLE_DEPTH);
  assign wr_addr = IDX_W'(in_entry_index);

  // covered length saturates at the table depth
  assign len_wide = CMP_W'(table_length_r);
  assign len_cov  = (len_wide > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(len_wide);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == tse_pkg::REG_TABLE_LENGTH)) begin
      table_length_r <= cfg_pwdata[tse_pkg::LEN_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == tse_pkg::REG_TABLE_LENGTH)
                      ? tse_pkg::APB_DATA_W'(table_length_r) : '0;

  tse_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tse_search_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_beat && (in_opcode != tse_pkg::OP_WRITE)),
    .start_op  (in_opcode),
    .start_key (key_ext),
    .start_len (len_cov),
    .idle      (idle),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the result beat
  assign out_tdata = {res.match_index, res.found};

endmodule

`default_nettype wire

// ===== src/tse_checker.sv =====
// tse_checker: port-level assertions of the table search engine
// bound to table_search_engine; uses tse_pkg widths
`timescale 1ns / 1ps
`default_nettype none

module tse_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [tse_pkg::IN_TDATA_W-1:0] in_tdata,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [tse_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                           cfg_pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // a search beat keeps the input closed in the cycle after it is taken
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] != tse_pkg::OP_WRITE) |=> !in_tready)
    else $error("input taken right after a search beat");

  // a write beat leaves the input open
  a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] == tse_pkg::OP_WRITE) |=> in_tready)
    else $error("write beat blocked the input");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[7:1] == 7'd0))
    else $error("not-found result with nonzero index");

  // configuration port never waits
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind table_search_engine tse_checker u_tse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

`default_nettype wire
